// File: src/kbp_pkg.sv
// Shared types, constants and command codes of the keyed token bucket policer.
// No dependencies; every other file imports this package.
package kbp_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int EVICT_SAMPLE_DEF  = 16;

   localparam int KEY_W      = 64;
   localparam int TOK_W      = 52;
   localparam int TIME_W     = 63;
   localparam int CNT_OUT_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_A_W    = 30;
   localparam int MUL_B_W    = 20;
   localparam int ACC_W      = 72;

   // 60e9 units per token, split at bit 30 for the multiply-accumulate
   localparam logic [TOK_W-1:0]   UNITS_PER_TOKEN = 52'd60000000000;
   localparam logic [MUL_A_W-1:0] UNITS_LO        = 30'd944199680;
   localparam logic [MUL_A_W-1:0] UNITS_HI        = 30'd55;
   localparam logic [MUL_A_W-1:0] NS_IN_SECOND    = 30'd1000000000;

   localparam logic [1:0] CMD_IDENT   = 2'd0;
   localparam logic [1:0] CMD_ADDR    = 2'd1;
   localparam logic [1:0] CMD_CLEANUP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDENT_CAP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENT_RPM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_CAP    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_RPM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDENT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_SEC    = 3'd6;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TOK_W-1:0]  tokens;
      logic [TIME_W-1:0] stamp;
   } kbp_entry_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MAC_FULL_LO,
      DP_MAC_FULL_HI,
      DP_SCAN,
      DP_DECIDE,
      DP_MAC_EL_LO,
      DP_MAC_EL_HI,
      DP_REFILL,
      DP_COMMIT,
      DP_MAC_SPAN_LO,
      DP_MAC_SPAN_HI,
      DP_CUTOFF,
      DP_SWEEP,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      scan_clr;
   } kbp_cmd_type;

   typedef struct packed {
      logic is_check;
      logic is_cleanup;
      logic scan_done;
      logic span_ok;
      logic rsp_free;
   } kbp_status_type;

endpackage

// File: src/kbp_table.sv
// One bucket table: entry memory with registered read, valid bits and fill count.
// Depends on kbp_pkg.
module kbp_table #(
   parameter int N = kbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rd_en,
   input  logic [((N > 1) ? $clog2(N) : 1)-1:0] rd_addr,
   output logic                   rd_valid,
   output kbp_pkg::kbp_entry_type rd_entry,
   input  logic                   wr_en,
   input  logic [((N > 1) ? $clog2(N) : 1)-1:0] wr_addr,
   input  kbp_pkg::kbp_entry_type wr_entry,
   input  logic                   clr_en,
   input  logic [((N > 1) ? $clog2(N) : 1)-1:0] clr_addr,
   output logic [$clog2(N+1)-1:0] count
);
   import kbp_pkg::*;

   localparam int CW = $clog2(N+1);

   kbp_entry_type entry_mem [N];
   kbp_entry_type rd_entry_ff;
   logic          rd_valid_ff;
   logic [N-1:0]  valid_ff, valid_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (clr_en && valid_ff[clr_addr]) begin
         valid_in[clr_addr] = 1'b0;
         count_in           = count_in - CW'(1);
      end
      if (wr_en && !valid_in[wr_addr]) begin
         valid_in[wr_addr] = 1'b1;
         count_in          = count_in + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;
   assign count    = count_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("fill count differs from valid bits");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written entry not valid");

   a_clear_drops_valid: assert property (@(posedge clock) disable iff (reset)
      clr_en && !(wr_en && wr_addr == clr_addr) |=> !valid_ff[$past(clr_addr)])
      else $error("cleared entry still valid");

endmodule

// File: src/kbp_datapath.sv
// Datapath: config registers, request capture, shared multiply-accumulate, table
// scan bookkeeping, refill and spend, result register. Depends on kbp_pkg, kbp_table.
module kbp_datapath #(
   parameter int N     = kbp_pkg::TABLE_ENTRIES_DEF,
   parameter int EVICT = kbp_pkg::EVICT_SAMPLE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [kbp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kbp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [1:0]                        req_cmd,
   input  logic [kbp_pkg::KEY_W-1:0]         req_lookup_key,
   input  logic [kbp_pkg::TIME_W-1:0]        req_now_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_verdict,
   output logic [kbp_pkg::CNT_OUT_W-1:0]     rsp_ident_entries,
   output logic [kbp_pkg::CNT_OUT_W-1:0]     rsp_addr_entries,
   input  kbp_pkg::kbp_cmd_type              dp_cmd,
   output kbp_pkg::kbp_status_type           status
);
   import kbp_pkg::*;

   localparam int AW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(N+1);
   localparam int SW = $clog2(EVICT+1);
   localparam int LW = (CW > 7) ? CW : 7;

   // configuration
   logic [15:0] ident_cap_ff, addr_cap_ff;
   logic [19:0] ident_rpm_ff, addr_rpm_ff;
   logic [6:0]  ident_lim_ff, addr_lim_ff;
   logic [31:0] idle_sec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_cap_ff <= 16'd60;
         ident_rpm_ff <= 20'd60;
         addr_cap_ff  <= 16'd60;
         addr_rpm_ff  <= 20'd0;
         ident_lim_ff <= 7'd64;
         addr_lim_ff  <= 7'd64;
         idle_sec_ff  <= 32'd300;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IDENT_CAP:   ident_cap_ff <= csr_wdata[15:0];
            CSR_IDENT_RPM:   ident_rpm_ff <= csr_wdata[19:0];
            CSR_ADDR_CAP:    addr_cap_ff  <= csr_wdata[15:0];
            CSR_ADDR_RPM:    addr_rpm_ff  <= csr_wdata[19:0];
            CSR_IDENT_LIMIT: ident_lim_ff <= csr_wdata[6:0];
            CSR_ADDR_LIMIT:  addr_lim_ff  <= csr_wdata[6:0];
            CSR_IDLE_SEC:    idle_sec_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request
   logic [1:0]        cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] now_ff;
   logic              tsel_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.op == DP_LOAD) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_lookup_key;
         now_ff  <= req_now_time;
         tsel_ff <= (req_cmd == CMD_ADDR);
      end
   end

   logic [15:0] cap_sel;
   logic [19:0] rpm_sel;
   logic [6:0]  lim_sel;
   assign cap_sel = tsel_ff ? addr_cap_ff : ident_cap_ff;
   assign rpm_sel = tsel_ff ? addr_rpm_ff : ident_rpm_ff;
   assign lim_sel = tsel_ff ? addr_lim_ff : ident_lim_ff;

   // multiply-accumulate
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [MUL_A_W+MUL_B_W-1:0] prod;
   logic [ACC_W-1:0]           prod_sh, acc_ff, acc_in;
   logic [TOK_W-1:0]           full_ff, full_in;
   logic [TIME_W-1:0]          elapsed_ff, elapsed_in;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (dp_cmd.op)
         DP_MAC_FULL_LO: begin mul_a = UNITS_LO; mul_b = MUL_B_W'(cap_sel); end
         DP_MAC_FULL_HI: begin mul_a = UNITS_HI; mul_b = MUL_B_W'(cap_sel); end
         DP_MAC_EL_LO:   begin mul_a = elapsed_ff[29:0]; mul_b = rpm_sel; end
         DP_MAC_EL_HI:   begin mul_a = MUL_A_W'(elapsed_ff[51:30]); mul_b = rpm_sel; end
         DP_MAC_SPAN_LO: begin mul_a = NS_IN_SECOND; mul_b = MUL_B_W'(idle_sec_ff[15:0]); end
         DP_MAC_SPAN_HI: begin mul_a = NS_IN_SECOND; mul_b = MUL_B_W'(idle_sec_ff[31:16]); end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      prod_sh = ACC_W'(prod);
      acc_in  = acc_ff;
      full_in = full_ff;
      case (dp_cmd.op)
         DP_MAC_FULL_LO, DP_MAC_EL_LO, DP_MAC_SPAN_LO: acc_in = prod_sh;
         DP_MAC_FULL_HI: begin
            acc_in  = acc_ff + (prod_sh << 30);
            full_in = acc_in[TOK_W-1:0];
         end
         DP_MAC_EL_HI:   acc_in = acc_ff + (prod_sh << 30);
         DP_MAC_SPAN_HI: acc_in = acc_ff + (prod_sh << 16);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      full_ff <= full_in;
   end

   // tables
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          i_rd_valid, a_rd_valid;
   kbp_entry_type i_rd_entry, a_rd_entry;
   logic          i_wr_en, a_wr_en;
   kbp_entry_type wr_entry;
   logic          i_clr_en, a_clr_en;
   logic [AW-1:0] clr_addr;
   logic [CW-1:0] i_count, a_count;

   // scan bookkeeping
   logic [CW-1:0]     issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              free_found_ff, free_found_in;
   logic [AW-1:0]     free_ff, free_in;
   logic              vic_found_ff, vic_found_in;
   logic [AW-1:0]     vic_ff, vic_in;
   logic [TIME_W-1:0] vic_stamp_ff, vic_stamp_in;
   logic [SW-1:0]     seen_ff, seen_in;
   logic [TOK_W-1:0]  tok_ff, tok_in;
   logic [TIME_W-1:0] st_ff, st_in;
   logic [TOK_W-1:0]  head_ff, head_in;
   logic              ge_full_ff, ge_full_in;
   logic              big_el_ff, big_el_in;
   logic              verdict_ff, verdict_in;
   logic              span_ok_ff, span_ok_in;
   logic [TIME_W-1:0] cutoff_ff, cutoff_in;

   logic              scanning, sel_valid, over_lim, evict, spend;
   kbp_entry_type     sel_entry;
   logic [LW-1:0]     lim_eff, cnt_sel;
   logic [TIME_W-1:0] st_pick;
   logic [TOK_W-1:0]  new_tok;
   logic [61:0]       span;

   assign scanning  = (dp_cmd.op == DP_SCAN) || (dp_cmd.op == DP_SWEEP);
   assign rd_en     = scanning && (issue_ff != CW'(N));
   assign rd_addr   = issue_ff[AW-1:0];
   assign sel_valid = tsel_ff ? a_rd_valid : i_rd_valid;
   assign sel_entry = tsel_ff ? a_rd_entry : i_rd_entry;
   assign span      = acc_ff[61:0];

   always_comb begin
      lim_eff = LW'(lim_sel);
      if (lim_sel == 7'd0) begin
         lim_eff = LW'(1);
      end
      if (lim_eff > LW'(N)) begin
         lim_eff = LW'(N);
      end
   end

   assign cnt_sel  = tsel_ff ? LW'(a_count) : LW'(i_count);
   assign over_lim = cnt_sel >= lim_eff;
   assign evict    = !found_ff && over_lim && vic_found_ff;
   assign spend    = tok_ff >= UNITS_PER_TOKEN;
   assign new_tok  = spend ? tok_ff - UNITS_PER_TOKEN : tok_ff;
   assign st_pick  = found_ff ? st_ff : now_ff;

   always_comb begin
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      free_found_in = free_found_ff;
      free_in       = free_ff;
      vic_found_in  = vic_found_ff;
      vic_in        = vic_ff;
      vic_stamp_in  = vic_stamp_ff;
      seen_in       = seen_ff;
      tok_in        = tok_ff;
      st_in         = st_ff;
      head_in       = head_ff;
      ge_full_in    = ge_full_ff;
      big_el_in     = big_el_ff;
      verdict_in    = verdict_ff;
      elapsed_in    = elapsed_ff;
      span_ok_in    = span_ok_ff;
      cutoff_in     = cutoff_ff;

      if (dp_cmd.scan_clr) begin
         issue_in      = '0;
         pend_in       = 1'b0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         vic_found_in  = 1'b0;
         seen_in       = '0;
      end else if (scanning) begin
         pend_in = rd_en;
         pidx_in = rd_addr;
         if (rd_en) begin
            issue_in = issue_ff + CW'(1);
         end
      end

      // take in one read response of the key scan
      if (dp_cmd.op == DP_SCAN && pend_ff) begin
         if (sel_valid && sel_entry.key == key_ff && !found_ff) begin
            found_in = 1'b1;
            slot_in  = pidx_ff;
            tok_in   = sel_entry.tokens;
            st_in    = sel_entry.stamp;
         end
         if (!sel_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_in       = pidx_ff;
         end
         if (sel_valid && seen_ff != SW'(EVICT)) begin
            seen_in = seen_ff + SW'(1);
            if (!vic_found_ff || sel_entry.stamp < vic_stamp_ff) begin
               vic_found_in = 1'b1;
               vic_in       = pidx_ff;
               vic_stamp_in = sel_entry.stamp;
            end
         end
      end

      case (dp_cmd.op)
         DP_LOAD: verdict_in = 1'b0;
         DP_DECIDE: begin
            if (!found_ff) begin
               slot_in = (evict && (!free_found_ff || vic_ff < free_ff)) ? vic_ff : free_ff;
               tok_in  = full_ff;
            end
            elapsed_in = (now_ff > st_pick) ? now_ff - st_pick : '0;
         end
         DP_MAC_EL_LO: begin
            head_in    = full_ff - tok_ff;
            ge_full_in = tok_ff >= full_ff;
            big_el_in  = elapsed_ff[TIME_W-1:TOK_W] != '0;
         end
         DP_REFILL: begin
            if (ge_full_ff) begin
               tok_in = full_ff;
            end else if (rpm_sel != 20'd0) begin
               if (big_el_ff || acc_ff > ACC_W'(head_ff)) begin
                  tok_in = full_ff;
               end else begin
                  tok_in = tok_ff + acc_ff[TOK_W-1:0];
               end
            end
         end
         DP_COMMIT: verdict_in = !spend;
         DP_CUTOFF: begin
            span_ok_in = TIME_W'(span) <= now_ff;
            cutoff_in  = now_ff - TIME_W'(span);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         seen_ff       <= '0;
         span_ok_ff    <= 1'b0;
      end else begin
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         vic_found_ff  <= vic_found_in;
         seen_ff       <= seen_in;
         span_ok_ff    <= span_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff      <= pidx_in;
      slot_ff      <= slot_in;
      free_ff      <= free_in;
      vic_ff       <= vic_in;
      vic_stamp_ff <= vic_stamp_in;
      tok_ff       <= tok_in;
      st_ff        <= st_in;
      head_ff      <= head_in;
      ge_full_ff   <= ge_full_in;
      big_el_ff    <= big_el_in;
      verdict_ff   <= verdict_in;
      elapsed_ff   <= elapsed_in;
      cutoff_ff    <= cutoff_in;
   end

   // table writes and clears
   assign wr_entry = '{key: key_ff, tokens: new_tok, stamp: now_ff};
   assign i_wr_en  = (dp_cmd.op == DP_COMMIT) && !tsel_ff;
   assign a_wr_en  = (dp_cmd.op == DP_COMMIT) && tsel_ff;
   assign clr_addr = (dp_cmd.op == DP_DECIDE) ? vic_ff : pidx_ff;
   assign i_clr_en = ((dp_cmd.op == DP_SWEEP) && pend_ff && i_rd_valid &&
                      i_rd_entry.stamp < cutoff_ff) ||
                     ((dp_cmd.op == DP_DECIDE) && evict && !tsel_ff);
   assign a_clr_en = ((dp_cmd.op == DP_SWEEP) && pend_ff && a_rd_valid &&
                      a_rd_entry.stamp < cutoff_ff) ||
                     ((dp_cmd.op == DP_DECIDE) && evict && tsel_ff);

   kbp_table #(.N(N)) u_ident_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_valid (i_rd_valid),
      .rd_entry (i_rd_entry),
      .wr_en    (i_wr_en),
      .wr_addr  (slot_ff),
      .wr_entry (wr_entry),
      .clr_en   (i_clr_en),
      .clr_addr (clr_addr),
      .count    (i_count)
   );

   kbp_table #(.N(N)) u_addr_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_valid (a_rd_valid),
      .rd_entry (a_rd_entry),
      .wr_en    (a_wr_en),
      .wr_addr  (slot_ff),
      .wr_entry (wr_entry),
      .clr_en   (a_clr_en),
      .clr_addr (clr_addr),
      .count    (a_count)
   );

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_verdict_ff;
   logic [CNT_OUT_W-1:0] rsp_ident_ff, rsp_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.op == DP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == DP_RESULT) begin
         rsp_verdict_ff <= verdict_ff;
         rsp_ident_ff   <= CNT_OUT_W'(i_count);
         rsp_addr_ff    <= CNT_OUT_W'(a_count);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_ident_entries = rsp_ident_ff;
   assign rsp_addr_entries  = rsp_addr_ff;

   assign status.is_check   = (cmd_ff == CMD_IDENT) ||
                              (cmd_ff == CMD_ADDR && addr_rpm_ff != 20'd0);
   assign status.is_cleanup = (cmd_ff == CMD_CLEANUP);
   assign status.scan_done  = (issue_ff == CW'(N)) && !pend_ff;
   assign status.span_ok    = span_ok_ff;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

// File: src/kbp_ctrl.sv
// Controller state machine: sequences the datapath through check and cleanup.
// Depends on kbp_pkg.
module kbp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  kbp_pkg::kbp_status_type status,
   output kbp_pkg::kbp_cmd_type    dp_cmd
);
   import kbp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FULL_LO,
      ST_FULL_HI,
      ST_SCAN,
      ST_DECIDE,
      ST_EL_LO,
      ST_EL_HI,
      ST_REFILL,
      ST_COMMIT,
      ST_SPAN_LO,
      ST_SPAN_HI,
      ST_CUTOFF,
      ST_SPAN_CHK,
      ST_SWEEP,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      dp_cmd.op       = DP_NOP;
      dp_cmd.scan_clr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.op       = DP_LOAD;
               dp_cmd.scan_clr = 1'b1;
               state_in        = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_check) begin
               state_in = ST_FULL_LO;
            end else if (status.is_cleanup) begin
               state_in = ST_SPAN_LO;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_FULL_LO: begin dp_cmd.op = DP_MAC_FULL_LO; state_in = ST_FULL_HI; end
         ST_FULL_HI: begin dp_cmd.op = DP_MAC_FULL_HI; state_in = ST_SCAN; end
         ST_SCAN: begin
            dp_cmd.op = DP_SCAN;
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin dp_cmd.op = DP_DECIDE; state_in = ST_EL_LO; end
         ST_EL_LO:  begin dp_cmd.op = DP_MAC_EL_LO; state_in = ST_EL_HI; end
         ST_EL_HI:  begin dp_cmd.op = DP_MAC_EL_HI; state_in = ST_REFILL; end
         ST_REFILL: begin dp_cmd.op = DP_REFILL; state_in = ST_COMMIT; end
         ST_COMMIT: begin dp_cmd.op = DP_COMMIT; state_in = ST_RESULT; end
         ST_SPAN_LO: begin dp_cmd.op = DP_MAC_SPAN_LO; state_in = ST_SPAN_HI; end
         ST_SPAN_HI: begin dp_cmd.op = DP_MAC_SPAN_HI; state_in = ST_CUTOFF; end
         ST_CUTOFF: begin
            dp_cmd.op       = DP_CUTOFF;
            dp_cmd.scan_clr = 1'b1;
            state_in        = ST_SPAN_CHK;
         end
         ST_SPAN_CHK: begin
            state_in = status.span_ok ? ST_SWEEP : ST_RESULT;
         end
         ST_SWEEP: begin
            dp_cmd.op = DP_SWEEP;
            if (status.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               dp_cmd.op = DP_RESULT;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// File: src/keyed_token_bucket_policer.sv
// A check's time is set by the one-read-per-cycle key scan of the bucket memory; a
// cleanup walks both tables, unless the cutoff falls below zero; an address check
// with zero rate or an unused command goes straight to the result. A result is
// loaded only once the previous result has been taken or is being taken.
// Throughput: one transaction at a time; the next request is taken the cycle after the
// result is loaded, even while that result still waits for rsp_ready.
// Reset clears all valid bits and fill counts at once and loads the register defaults.
module keyed_token_bucket_policer #(
   parameter int TABLE_ENTRIES = kbp_pkg::TABLE_ENTRIES_DEF,
   parameter int EVICT_SAMPLE  = kbp_pkg::EVICT_SAMPLE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [kbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kbp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_cmd,
   input  logic [kbp_pkg::KEY_W-1:0]      req_lookup_key,
   input  logic [kbp_pkg::TIME_W-1:0]     req_now_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_verdict,
   output logic [kbp_pkg::CNT_OUT_W-1:0]  rsp_ident_entries,
   output logic [kbp_pkg::CNT_OUT_W-1:0]  rsp_addr_entries
);
   import kbp_pkg::*;

   // Command flow between sequencer and datapath:
   //   check: full = capacity * 60e9 in two multiply-accumulate steps, scan the
   //   table for the key, the first free slot and the oldest of the first
   //   EVICT_SAMPLE valid slots, evict if at the limit, then refill by
   //   elapsed * rate (two more steps), spend one token and write back.
   //   cleanup: span = idle seconds * 1e9, then walk both tables together and
   //   drop every entry stamped before the cutoff.
   kbp_cmd_type    dp_cmd;
   kbp_status_type status;

   kbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   kbp_datapath #(
      .N     (TABLE_ENTRIES),
      .EVICT (EVICT_SAMPLE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_cmd           (req_cmd),
      .req_lookup_key    (req_lookup_key),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_ident_entries (rsp_ident_entries),
      .rsp_addr_entries  (rsp_addr_entries),
      .dp_cmd            (dp_cmd),
      .status            (status)
   );

endmodule

// File: bench/tb_keyed_token_bucket_policer.sv
// Self-checking bench for keyed_token_bucket_policer: drives check and cleanup transactions,
// predicts each response with a local bucket-table model and compares field by field.
// Depends on kbp_pkg and the keyed_token_bucket_policer RTL.
module tb_keyed_token_bucket_policer;
   import kbp_pkg::*;

   localparam int SLOTS  = TABLE_ENTRIES_DEF;
   localparam int SAMPLE = EVICT_SAMPLE_DEF;
   localparam logic [63:0] UNIT_SCALE = 64'd60000000000;
   localparam logic [63:0] NS_SEC     = 64'd1000000000;
   localparam int ID_TAB = 0;
   localparam int AD_TAB = 1;

   typedef struct {
      logic [1:0]        cmd;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
   } policer_req_type;

   typedef struct {
      logic                 verdict;
      logic [CNT_OUT_W-1:0] ident_n;
      logic [CNT_OUT_W-1:0] addr_n;
   } policer_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic [KEY_W-1:0] req_lookup_key = '0;
   logic [TIME_W-1:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_verdict;
   logic [CNT_OUT_W-1:0] rsp_ident_entries;
   logic [CNT_OUT_W-1:0] rsp_addr_entries;

   keyed_token_bucket_policer dut (.*);

   always #4 clock = ~clock;

   // Local copy of the register file
   logic [63:0] cap_reg [2];
   logic [63:0] rpm_reg [2];
   logic [63:0] limit_reg [2];
   logic [63:0] idle_sec;

   // Local copy of both bucket tables
   bit          bkt_valid [2][SLOTS];
   logic [63:0] bkt_key [2][SLOTS];
   logic [63:0] bkt_tokens [2][SLOTS];
   logic [63:0] bkt_stamp [2][SLOTS];

   policer_req_type pending_reqs[$];
   policer_rsp_type expected_rsps[$];
   int  error_count = 0;
   bit  req_taken = 1'b0;
   bit  quiet = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   logic [63:0] clock_ns = 0;
   logic [63:0] key_pool [24];

   function automatic int live_count(int t);
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (bkt_valid[t][i]) n++;
      return n;
   endfunction

   // Find or create the bucket, refill it, then spend a token; returns 1 when limited
   function automatic logic spend_token(int t, logic [63:0] k, logic [63:0] now);
      logic [63:0] full, lim, elapsed, tok, head;
      int slot, victim, seen;
      full = cap_reg[t] * UNIT_SCALE;
      slot = -1;
      for (int i = 0; i < SLOTS; i++)
         if (slot < 0 && bkt_valid[t][i] && bkt_key[t][i] == k) slot = i;
      if (slot < 0) begin
         lim = limit_reg[t];
         if (lim == 0) lim = 1;
         if (lim > SLOTS) lim = SLOTS;
         if (live_count(t) >= lim) begin
            victim = -1;
            seen = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (bkt_valid[t][i] && seen < SAMPLE) begin
                  seen++;
                  if (victim < 0 || bkt_stamp[t][i] < bkt_stamp[t][victim]) victim = i;
               end
            end
            if (victim >= 0) bkt_valid[t][victim] = 1'b0;
         end
         for (int i = 0; i < SLOTS; i++)
            if (slot < 0 && !bkt_valid[t][i]) slot = i;
         bkt_valid[t][slot] = 1'b1;
         bkt_key[t][slot] = k;
         bkt_tokens[t][slot] = full;
         bkt_stamp[t][slot] = now;
      end
      elapsed = (now > bkt_stamp[t][slot]) ? now - bkt_stamp[t][slot] : 64'd0;
      tok = bkt_tokens[t][slot];
      if (tok >= full) begin
         tok = full;
      end else if (rpm_reg[t] != 0) begin
         head = full - tok;
         if (elapsed > head / rpm_reg[t]) tok = full;
         else tok = tok + elapsed * rpm_reg[t];
      end
      bkt_stamp[t][slot] = now;
      if (tok >= UNIT_SCALE) begin
         bkt_tokens[t][slot] = tok - UNIT_SCALE;
         return 1'b0;
      end
      bkt_tokens[t][slot] = tok;
      return 1'b1;
   endfunction

   function automatic policer_rsp_type predict_policer(policer_req_type r);
      policer_rsp_type o;
      logic [63:0] span;
      o.verdict = 1'b0;
      if (r.cmd == CMD_IDENT) begin
         o.verdict = spend_token(ID_TAB, r.key, {1'b0, r.now});
      end else if (r.cmd == CMD_ADDR) begin
         if (rpm_reg[AD_TAB] != 0) o.verdict = spend_token(AD_TAB, r.key, {1'b0, r.now});
      end else if (r.cmd == CMD_CLEANUP) begin
         span = idle_sec * NS_SEC;
         if (span <= {1'b0, r.now}) begin
            for (int t = 0; t < 2; t++)
               for (int i = 0; i < SLOTS; i++)
                  if (bkt_valid[t][i] && bkt_stamp[t][i] < {1'b0, r.now} - span)
                     bkt_valid[t][i] = 1'b0;
         end
      end
      o.ident_n = CNT_OUT_W'(live_count(ID_TAB));
      o.addr_n = CNT_OUT_W'(live_count(AD_TAB));
      return o;
   endfunction

   // Request side: predict on every accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(predict_policer('{req_cmd, req_lookup_key, req_now_time}));
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   // Driver: hold the payload until accepted, then advance or idle for a burst
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            policer_req_type r;
            r = pending_reqs.pop_front();
            req_cmd <= r.cmd;
            req_lookup_key <= r.key;
            req_now_time <= r.now;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random back-pressure bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         recv_gap = $urandom_range(1, 10) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no prediction pending");
            error_count++;
         end else begin
            policer_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_verdict !== e.verdict) begin
               $error("verdict: expected %0d actual %0d", e.verdict, rsp_verdict);
               error_count++;
            end
            if (rsp_ident_entries !== e.ident_n) begin
               $error("ident_entries: expected %0d actual %0d", e.ident_n, rsp_ident_entries);
               error_count++;
            end
            if (rsp_addr_entries !== e.addr_n) begin
               $error("addr_entries: expected %0d actual %0d", e.addr_n, rsp_addr_entries);
               error_count++;
            end
         end
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_IDENT_CAP:   cap_reg[ID_TAB] = 64'(val[15:0]);
         CSR_IDENT_RPM:   rpm_reg[ID_TAB] = 64'(val[19:0]);
         CSR_ADDR_CAP:    cap_reg[AD_TAB] = 64'(val[15:0]);
         CSR_ADDR_RPM:    rpm_reg[AD_TAB] = 64'(val[19:0]);
         CSR_IDENT_LIMIT: limit_reg[ID_TAB] = 64'(val[6:0]);
         CSR_ADDR_LIMIT:  limit_reg[AD_TAB] = 64'(val[6:0]);
         CSR_IDLE_SEC:    idle_sec = 64'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_all_csrs(int ic, int ir, int ac, int ar, int il, int al,
                                 logic [31:0] idle);
      write_csr(CSR_IDENT_CAP, ic);
      write_csr(CSR_IDENT_RPM, ir);
      write_csr(CSR_ADDR_CAP, ac);
      write_csr(CSR_ADDR_RPM, ar);
      write_csr(CSR_IDENT_LIMIT, il);
      write_csr(CSR_ADDR_LIMIT, al);
      write_csr(CSR_IDLE_SEC, idle);
   endtask

   // Hold off until every queued transaction has been answered, checked at clock edges
   task automatic drain_policer;
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void queue_req(logic [1:0] c, logic [63:0] k, logic [63:0] n);
      pending_reqs.push_back('{c, k, n[TIME_W-1:0]});
   endfunction

   // Mostly pooled keys on an advancing clock; some backward and wild times
   function automatic void queue_random_req();
      int pick;
      logic [1:0] c;
      logic [63:0] k;
      pick = $urandom_range(0, 99);
      if (pick < 45) c = CMD_IDENT;
      else if (pick < 80) c = CMD_ADDR;
      else if (pick < 95) c = CMD_CLEANUP;
      else c = 2'd3;
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 23)];
      else k = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ns = clock_ns - $urandom_range(0, 2000000000);
      else if (pick < 5) clock_ns = {$urandom, $urandom} >> 1;
      else if (pick < 10) clock_ns = clock_ns + 64'($urandom_range(0, 600)) * NS_SEC;
      else clock_ns = clock_ns + $urandom_range(0, 1500000000);
      clock_ns[63] = 1'b0;
      queue_req(c, k, clock_ns);
   endfunction

   initial begin
      cap_reg[ID_TAB] = 60; rpm_reg[ID_TAB] = 60; limit_reg[ID_TAB] = 64;
      cap_reg[AD_TAB] = 60; rpm_reg[AD_TAB] = 0;  limit_reg[AD_TAB] = 64;
      idle_sec = 300;
      for (int t = 0; t < 2; t++)
         for (int i = 0; i < SLOTS; i++) bkt_valid[t][i] = 1'b0;
      for (int i = 0; i < 24; i++) key_pool[i] = (i < 2) ? {64{i[0]}} : {$urandom, $urandom};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extreme keys and times, every command
      queue_req(CMD_IDENT, 64'd0, 64'd0);
      queue_req(CMD_IDENT, '1, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_req(CMD_ADDR, 64'h1234, 64'd5);
      queue_req(CMD_CLEANUP, 64'd0, 64'd10);
      queue_req(2'd3, '1, 64'd20);
      queue_req(CMD_IDENT, 64'd0, 64'd0);
      drain_policer();

      // Directed: tiny buckets and tables to hit limiting, eviction, backward time
      write_all_csrs(1, 1, 2, 1, 2, 0, 0);
      queue_req(CMD_IDENT, 64'd7, 64'd1000);
      queue_req(CMD_IDENT, 64'd7, 64'd1001);
      queue_req(CMD_IDENT, 64'd7, 64'd500);
      queue_req(CMD_IDENT, 64'd8, 64'd2000);
      queue_req(CMD_IDENT, 64'd9, 64'd3000);
      queue_req(CMD_ADDR, 64'd7, 64'd3000);
      queue_req(CMD_ADDR, 64'd7, 64'd3001);
      queue_req(CMD_ADDR, 64'd7, 64'd3002);
      queue_req(CMD_ADDR, 64'd5, 64'd3003);
      queue_req(CMD_IDENT, 64'd7, 64'd3000 + 64'd60000000000);
      queue_req(CMD_CLEANUP, 64'd0, 64'd3500);
      drain_policer();

      // Directed: capacity zero, maximum rate, full idle span, limit raised to 64
      write_all_csrs(0, 1048575, 65535, 1048575, 64, 64, 32'hFFFF_FFFF);
      queue_req(CMD_IDENT, 64'd1, 64'd100);
      queue_req(CMD_ADDR, 64'd1, 64'd100);
      queue_req(CMD_CLEANUP, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_req(CMD_CLEANUP, 64'd0, 64'd1000);
      drain_policer();

      // Random phases, each with fresh settings; last one runs without idling
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) quiet = 1'b1;
         write_all_csrs($urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 5),
                        $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                                  : $urandom_range(0, 90),
                        $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 5),
                        $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 90),
                        $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 64),
                        $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 64),
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400));
         for (int n = 0; n < 105; n++) queue_random_req();
         drain_policer();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
